// ===== hw/rtl/fdrle_pkg.sv =====
// ----------------------------------------------------------------------------
// fdrle_pkg
// Types, constants and helpers shared by the frame delta run-length encoder.
// ----------------------------------------------------------------------------
package fdrle_pkg;

  localparam int unsigned MaxPixels = 16384;
  localparam int unsigned PosW      = $clog2(MaxPixels);
  localparam int unsigned ColorW    = 24;
  localparam int unsigned CountW    = 15;
  localparam int unsigned NumTok    = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [PosW-1:0]   PosLast  = PosW'(MaxPixels - 1);

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_DRAW = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_END  = 2'd3
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e           kind;
    logic [ColorW-1:0]   color;
    logic [CountW-1:0]   count;
    logic                last;
  } token_t;

  typedef struct packed {
    token_t [NumTok-1:0] tok;
    logic   [1:0]        num;
  } tok_list_t;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              eof;
  } pixel_t;

  typedef struct packed {
    logic              known;
    logic [ColorW-1:0] color;
  } prev_t;

  // A run of one pixel goes out as a single draw
  function automatic token_t close_token(logic [ColorW-1:0] c, logic [CountW-1:0] len);
    token_t t;
    t.color = c;
    t.last  = 1'b0;
    if (len > CountW'(1)) begin
      t.kind  = KIND_RUN;
      t.count = len;
    end else begin
      t.kind  = KIND_DRAW;
      t.count = '0;
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/fdrle_frame_store.sv =====
// ----------------------------------------------------------------------------
// fdrle_frame_store
// Previous-frame memory with raster position and fill tracking. Read-first:
// the old pixel is registered while the new one is written at the same slot.
// ----------------------------------------------------------------------------
module fdrle_frame_store
  import fdrle_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  pixel_t pixel_i,
  output prev_t  prev_o
);

  logic [ColorW-1:0] mem [MaxPixels];
  logic [ColorW-1:0] rd_q;
  logic              known_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW:0]     fill_q, fill_d;

  // Slots are always visited as a prefix from zero, so slots below the fill
  // count have been written and the rest are unwritten and read back as zero.
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (wr_en_i) begin
      if (pixel_i.eof || pos_q == PosLast) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
      if ({1'b0, pos_q} == fill_q) begin
        fill_d = fill_q + (PosW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fill_q  <= '0;
      known_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      if (wr_en_i) begin
        known_q <= ({1'b0, pos_q} < fill_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q        <= mem[pos_q];
      mem[pos_q]  <= pixel_i.color;
    end
  end

  assign prev_o.known = known_q;
  assign prev_o.color = known_q ? rd_q : '0;

  a_pos_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q} <= fill_q))
    else $error("position beyond fill count");

endmodule

// ===== hw/rtl/fdrle_token_gen.sv =====
// ----------------------------------------------------------------------------
// fdrle_token_gen
// Skip/run state and token list for one pixel, committed on advance.
// ----------------------------------------------------------------------------
module fdrle_token_gen
  import fdrle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  pixel_t    pixel_i,
  input  prev_t     prev_i,
  output tok_list_t list_o
);

  logic [CountW-1:0] skip_q, skip_d;
  logic [CountW-1:0] run_len_q, run_len_d;
  logic [ColorW-1:0] run_color_q, run_color_d;
  logic              run_open_q, run_open_d;

  logic              unchanged;
  logic [NumTok-1:0] cand_v;
  token_t            cand_t [NumTok];
  logic [1:0]        n;

  always_comb begin
    unchanged   = (prev_i.color == pixel_i.color);
    skip_d      = skip_q;
    run_len_d   = run_len_q;
    run_color_d = run_color_q;
    run_open_d  = run_open_q;
    cand_v      = '0;
    cand_t[0]   = '0;
    cand_t[1]   = '0;
    cand_t[2]   = '0;

    if (run_open_q && pixel_i.color == run_color_q) begin
      if (run_len_q != CountMax) begin
        run_len_d = run_len_q + CountW'(1);
      end
    end else begin
      // A skip count is only pending while no run is open
      if (run_open_q) begin
        cand_v[0]  = 1'b1;
        cand_t[0]  = close_token(run_color_q, run_len_q);
        run_open_d = 1'b0;
        run_len_d  = '0;
      end
      if (unchanged) begin
        if (skip_q != CountMax) begin
          skip_d = skip_q + CountW'(1);
        end
      end else begin
        if (skip_q != '0) begin
          cand_v[0]       = 1'b1;
          cand_t[0].kind  = KIND_SKIP;
          cand_t[0].count = skip_q;
        end
        skip_d      = '0;
        run_open_d  = 1'b1;
        run_color_d = pixel_i.color;
        run_len_d   = CountW'(1);
      end
    end

    if (pixel_i.eof) begin
      if (run_open_d) begin
        cand_v[1] = 1'b1;
        cand_t[1] = close_token(run_color_d, run_len_d);
      end
      cand_v[2]      = 1'b1;
      cand_t[2].kind = KIND_END;
      run_open_d     = 1'b0;
      run_len_d      = '0;
      skip_d         = '0;
      run_color_d    = '0;
    end
  end

  // Pack the candidates in order and flag the final one
  always_comb begin
    list_o = '0;
    n      = '0;
    for (int i = 0; i < NumTok; i++) begin
      if (cand_v[i]) begin
        list_o.tok[n] = cand_t[i];
        n             = n + 2'd1;
      end
    end
    if (n != '0) begin
      list_o.tok[n - 2'd1].last = 1'b1;
    end
    list_o.num = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      run_len_q   <= '0;
      run_color_q <= '0;
      run_open_q  <= 1'b0;
    end else if (adv_i) begin
      skip_q      <= skip_d;
      run_len_q   <= run_len_d;
      run_color_q <= run_color_d;
      run_open_q  <= run_open_d;
    end
  end

  a_no_skip_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_open_q |-> (skip_q == '0))
    else $error("skip count pending while a run is open");

endmodule

// ===== hw/rtl/frame_delta_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// frame_delta_run_length_encoder
// Compares each pixel with the previous frame and emits skip, draw, run and
// frame-end tokens.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  pixel in | in_valid_i/in_ready_o, red/green/blue,    | input
//           | end_of_frame_i                            |
//  token out| out_valid_o/out_ready_i, token_kind,      | output
//           | color, count, last_result_o               |
//
// One pixel per cycle while each pixel yields at most one token and the output
// is not stalled; a pixel's tokens (up to 3) hold the output port until taken.
// Frame-store read is registered with the pixel; tokens then fill the buffer.
// Reset needs no clearing pass: a fill count marks unwritten slots as zero.
// A stalled output keeps its token buffer; one pixel waits in the input stage.
module frame_delta_run_length_encoder
  import fdrle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic                end_of_frame_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          token_kind_o,
  output logic [ColorW-1:0]   color_o,
  output logic [CountW-1:0]   count_o,
  output logic                last_result_o
);

  pixel_t              pixel_in;
  pixel_t              a_pixel_q;
  logic                a_valid_q;
  logic                accept;
  logic                a_adv;
  logic                pop;
  logic                b_free;
  prev_t               prev;
  tok_list_t           list;
  token_t [NumTok-1:0] b_tok_q;
  logic [1:0]          b_n_q;

  assign pixel_in.color = {blue_i, green_i, red_i};
  assign pixel_in.eof   = end_of_frame_i;

  assign pop        = out_valid_o && out_ready_i;
  assign b_free     = (b_n_q == 2'd0) || (b_n_q == 2'd1 && pop);
  assign a_adv      = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || a_adv;
  assign accept     = in_valid_i && in_ready_o;

  fdrle_frame_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .pixel_i (pixel_in),
    .prev_o  (prev)
  );

  fdrle_token_gen u_tokens (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (a_adv),
    .pixel_i (a_pixel_q),
    .prev_i  (prev),
    .list_o  (list)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pixel_q <= pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_n_q <= '0;
    end else if (a_adv) begin
      b_n_q <= list.num;
    end else if (pop) begin
      b_n_q <= b_n_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_tok_q <= list.tok;
    end else if (pop) begin
      b_tok_q[0] <= b_tok_q[1];
      b_tok_q[1] <= b_tok_q[2];
    end
  end

  assign out_valid_o   = (b_n_q != 2'd0);
  assign token_kind_o  = b_tok_q[0].kind;
  assign color_o       = b_tok_q[0].color;
  assign count_o       = b_tok_q[0].count;
  assign last_result_o = b_tok_q[0].last;

  a_eof_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_pixel_q.eof) |-> (list.num != 2'd0 && list.tok[list.num - 2'd1].kind == KIND_END))
    else $error("frame end pixel without frame-end token");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && b_tok_q[0].kind == KIND_SKIP) |-> (count_o != '0))
    else $error("zero-length skip transaction");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && b_n_q == 2'd1) |-> last_result_o)
    else $error("final buffered token lacks last flag");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_n_q == 2'd0) |-> in_ready_o)
    else $error("input stalled with empty token buffer");

endmodule

// ===== tb/tb_frame_delta_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_delta_run_length_encoder
// Drives pixel frames into the encoder and checks every token against an
// in-bench model of the frame-difference run-length scheme: directed corner
// cases, a long output stall, and random frames built from repeated, run and
// noise pixels.
// ----------------------------------------------------------------------------
module tb_frame_delta_run_length_encoder;
  import fdrle_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    tok_kind_e         kind;
    logic [ColorW-1:0] color;
    logic [CountW-1:0] count;
    logic              last;
  } exp_token_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [7:0]        red_i          = '0;
  logic [7:0]        green_i        = '0;
  logic [7:0]        blue_i         = '0;
  logic              end_of_frame_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [1:0]        token_kind_o;
  logic [ColorW-1:0] color_o;
  logic [CountW-1:0] count_o;
  logic              last_result_o;

  frame_delta_run_length_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .color_o        (color_o),
    .count_o        (count_o),
    .last_result_o  (last_result_o)
  );

  // Encoder model state
  logic [ColorW-1:0] frame_store [MaxPixels];
  logic [PosW-1:0]   pix_pos;
  logic [CountW-1:0] skip_len;
  logic              run_active;
  logic [ColorW-1:0] run_col;
  logic [CountW-1:0] run_len;

  exp_token_t expected_tokens[$];
  int         errors       = 0;
  bit         tx_idle_en   = 1'b1;
  bit         rx_idle_en   = 1'b1;
  int         rx_hold_req  = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Model of one accepted pixel: queues the tokens it produces
  task automatic encode_pixel(input logic [ColorW-1:0] c, input logic eof);
    exp_token_t toks [3];
    int         n;
    logic       same;
    n    = 0;
    same = (frame_store[pix_pos] == c);
    frame_store[pix_pos] = c;

    if (run_active && c == run_col) begin
      if (run_len != CountMax) run_len++;
    end else begin
      if (run_active) begin
        toks[n] = (run_len > 1) ? exp_token_t'{KIND_RUN, run_col, run_len, 1'b0}
                                : exp_token_t'{KIND_DRAW, run_col, '0, 1'b0};
        n++;
        run_active = 1'b0;
        run_len    = '0;
      end
      if (same) begin
        if (skip_len != CountMax) skip_len++;
      end else begin
        if (skip_len != 0) begin
          toks[n] = exp_token_t'{KIND_SKIP, '0, skip_len, 1'b0};
          n++;
        end
        skip_len   = '0;
        run_active = 1'b1;
        run_col    = c;
        run_len    = CountW'(1);
      end
    end

    if (eof) begin
      if (run_active) begin
        toks[n] = (run_len > 1) ? exp_token_t'{KIND_RUN, run_col, run_len, 1'b0}
                                : exp_token_t'{KIND_DRAW, run_col, '0, 1'b0};
        n++;
        run_active = 1'b0;
        run_len    = '0;
      end
      toks[n] = exp_token_t'{KIND_END, '0, '0, 1'b0};
      n++;
      skip_len = '0;
      run_col  = '0;
      pix_pos  = '0;
    end else begin
      pix_pos = pix_pos + 1'b1;
    end

    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
  endtask

  // One pixel transaction; called right after a rising edge
  task automatic send_pixel(input logic [ColorW-1:0] c, input logic eof);
    int gap;
    gap = pick_gap(tx_idle_en);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    red_i          <= c[7:0];
    green_i        <= c[15:8];
    blue_i         <= c[23:16];
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    encode_pixel(c, eof);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Token receiver: checks each transaction and drives out_ready_i
  initial begin
    exp_token_t e;
    int         rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d color %0d count %0d",
                 token_kind_o, color_o, count_o);
          errors++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("token_kind", 32'(e.kind), 32'(token_kind_o));
          check_field("color", 32'(e.color), 32'(color_o));
          check_field("count", 32'(e.count), 32'(count_o));
          check_field("last_result", 32'(e.last), 32'(last_result_o));
        end
      end
      if (rx_hold_req > 0) begin
        rx_wait     = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
        rx_wait = pick_gap(rx_idle_en);
      end
    end
  end

  task automatic test_directed();
    // first frame against the cleared store
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);  // flushes a skip of two, opens a run
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h0000FF, 1'b0);  // run close, no skip pending
    send_pixel(24'h00FF00, 1'b0);  // single draws from here
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'h000000, 1'b0);  // closer is unchanged -> goes to skip
    send_pixel(24'h000000, 1'b1);  // trailing skip dropped
    // second frame against the first
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h030201, 1'b0);
    send_pixel(24'h030201, 1'b0);  // run extends over a changed pixel
    send_pixel(24'h0000FF, 1'b1);  // close, reopen, flush and end: three tokens
    // one-pixel frames
    send_pixel(24'h808080, 1'b1);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'h000000, 1'b1);  // unchanged frame gives only the end token
    send_pixel(24'hAA55AA, 1'b0);
    send_pixel(24'h55AA55, 1'b0);
    send_pixel(24'hAA55AA, 1'b1);
  endtask

  // Output held off while pixels keep coming, so the input must stall
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = 300;
    for (int i = 0; i < 80; i++) send_pixel((i % 2) ? 24'h123456 : 24'h654321, i == 79);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_frames(input int n_items);
    int                sent, len, r;
    logic [ColorW-1:0] c, prev_c;
    logic              eof;
    logic [ColorW-1:0] palette [4];
    palette = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hFF00FF};
    sent    = 0;
    prev_c  = '0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      // gap-free stretches now and then
      rx_idle_en = ($urandom_range(0, 4) != 0);
      tx_idle_en = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35)      c = frame_store[pix_pos];
        else if (r < 65) c = prev_c;
        else if (r < 85) c = palette[$urandom_range(0, 3)];
        else             c = ColorW'($urandom);
        // an occasional frame runs on without its end marker
        eof = (i == len - 1) && ($urandom_range(0, 19) != 0);
        send_pixel(c, eof);
        prev_c = c;
        sent++;
      end
    end
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  initial begin
    foreach (frame_store[i]) frame_store[i] = '0;
    pix_pos    = '0;
    skip_len   = '0;
    run_active = 1'b0;
    run_col    = '0;
    run_len    = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_frames(400);
    wait_drained();
    // give any stray token time to show up
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
